/* hw/rtl/rmvs_pkg.sv */
// shared constants and types of the running mean, variance and deviation unit
`default_nettype none

package rmvs_pkg;

  // count saturates at 2^MaxCountBits - 1
  localparam int unsigned MaxCountBits = 16;
  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] CountCap = CntW'((32'd1 << MaxCountBits) - 32'd1);

  localparam int unsigned SampleW = 24;
  localparam int unsigned SumW    = 40;
  localparam int unsigned SqW     = 64;
  localparam int unsigned MeanW   = 23;
  localparam int unsigned VarW    = 46;
  localparam int unsigned StdW    = 23;
  localparam int unsigned RootW   = 27;
  localparam int unsigned AccW    = 81;
  localparam int unsigned RemW    = 40;
  localparam int unsigned MulW    = 24;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned CsW     = 42;
  localparam int unsigned OutDataW = 96;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned StepW   = 6;

  // last step index of each sequencer phase
  localparam logic [StepW-1:0] MulALast = StepW'(5);
  localparam logic [StepW-1:0] MulBLast = StepW'(7);
  localparam logic [StepW-1:0] MulNLast = StepW'(1);
  localparam logic [StepW-1:0] DivVLast = StepW'(VarW - 1);
  localparam logic [StepW-1:0] DivMLast = StepW'(MeanW - 1);
  localparam logic [StepW-1:0] SqrtLast = StepW'(RootW - 1);

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StSqr  = 9'b000000010,
    StMulA = 9'b000000100,
    StMulB = 9'b000001000,
    StMulN = 9'b000010000,
    StDivV = 9'b000100000,
    StDivM = 9'b001000000,
    StSqrt = 9'b010000000,
    StFin  = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/running_mean_variance_stddev_unit.sv */
// top level: running mean, population variance and standard deviation
`default_nettype none

// A non-negative Q15.8 sample is accepted and squared on the shared
// multiplier, and in the StSqr state that follows the square is added to
// the sum of squares. A negative sample ends the set and starts the result
// sequence on the same multiplier and on one compare-subtract unit: count *
// sum of squares, sum * sum, count * count, the variance division (skipped
// when the difference is negative), the mean division and the square root,
// in that order, up to the result register (an empty set goes straight to
// it). The result waits in an output register, so the next set accumulates
// while it is pending; a following terminator finishes only once that
// register is free. The input is not ready during a sequence.
module running_mean_variance_stddev_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [rmvs_pkg::SampleW-1:0]   s_axis_tdata,  // [23:0] sample
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [22:0] mean, [68:23] variance, [91:69] std_dev, [95:92] zero
  output logic      [rmvs_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic      [rmvs_pkg::OutUserW-1:0]  m_axis_tuser   // [0] empty_set, [1] count_overflow
);
  import rmvs_pkg::*;

  state_e            st_q, st_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CntW-1:0]   cnt_q;
  logic [SumW-1:0]   sum_q;
  logic [SqW-1:0]    sq_q;
  logic              ovf_q;
  logic              out_vld_q;

  logic [AccW-1:0]     acc_q;
  logic [RemW-1:0]     rem_q;
  logic [VarW-1:0]     quot_q;
  logic [SumW-1:0]     den_q;
  logic [MeanW-1:0]    mean_q;
  logic [VarW-1:0]     var_q;
  logic [RootW-1:0]    root_q;
  logic [StdW-1:0]     std_q;
  logic                empty_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  logic             in_fire;
  logic             out_fire;
  logic             cnt_full;
  logic             fin_go;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_p;
  logic [6:0]       shamt;
  logic [AccW-1:0]  part;
  logic [CsW-1:0]   cs_a, cs_b, cs_diff;
  logic             cs_ge;
  logic [RemW-1:0]  step_rem;
  logic [VarW-1:0]  quot_nxt;

  assign s_axis_tready = (st_q == StIdle);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_fire      = m_axis_tvalid & m_axis_tready;
  assign cnt_full      = (cnt_q >= CountCap);
  assign fin_go        = (st_q == StFin) & ~out_vld_q;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    shamt = '0;
    case (st_q)
      StIdle: begin
        mul_a = {1'b0, s_axis_tdata[SampleW-2:0]};
        mul_b = {1'b0, s_axis_tdata[SampleW-2:0]};
      end
      StMulA: begin
        mul_a = MulW'(cnt_q);
        case (step_q[2:1])
          2'd0: begin
            mul_b = sq_q[23:0];
            shamt = 7'd0;
          end
          2'd1: begin
            mul_b = sq_q[47:24];
            shamt = 7'd24;
          end
          default: begin
            mul_b = MulW'(sq_q[63:48]);
            shamt = 7'd48;
          end
        endcase
      end
      StMulB: begin
        case (step_q[2:1])
          2'd0: begin
            mul_a = sum_q[23:0];
            mul_b = sum_q[23:0];
            shamt = 7'd0;
          end
          2'd1: begin
            mul_a = sum_q[23:0];
            mul_b = MulW'(sum_q[39:24]);
            shamt = 7'd24;
          end
          2'd2: begin
            mul_a = MulW'(sum_q[39:24]);
            mul_b = sum_q[23:0];
            shamt = 7'd24;
          end
          default: begin
            mul_a = MulW'(sum_q[39:24]);
            mul_b = MulW'(sum_q[39:24]);
            shamt = 7'd48;
          end
        endcase
      end
      StMulN: begin
        mul_a = MulW'(cnt_q);
        mul_b = MulW'(cnt_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    part = AccW'(mul_p) << shamt;
  end

  // operand selection for the compare-subtract unit
  always_comb begin
    cs_a = '0;
    cs_b = '0;
    case (st_q)
      StDivV: begin
        cs_a = {1'b0, rem_q, quot_q[VarW-1]};
        cs_b = CsW'(den_q);
      end
      StDivM: begin
        cs_a = {1'b0, rem_q, quot_q[VarW-1]};
        cs_b = CsW'(cnt_q);
      end
      StSqrt: begin
        // remainder*4 + next two bits against root*4 + 1
        cs_a = {rem_q, acc_q[53:52]};
        cs_b = {13'b0, root_q, 2'b01};
      end
      default: begin
        cs_a = '0;
        cs_b = '0;
      end
    endcase
    step_rem = cs_ge ? cs_diff[RemW-1:0] : cs_a[RemW-1:0];
    quot_nxt = {quot_q[VarW-2:0], cs_ge};
  end

  rmvs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  rmvs_csub u_csub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .ge_o   (cs_ge),
    .diff_o (cs_diff)
  );

  // sequencer
  always_comb begin
    st_d   = st_q;
    step_d = step_q + StepW'(1);
    case (st_q)
      StIdle: begin
        step_d = '0;
        if (in_fire) begin
          if (!s_axis_tdata[SampleW-1]) begin
            if (!cnt_full) begin
              st_d = StSqr;
            end
          end else if (cnt_q == '0) begin
            st_d = StFin;
          end else begin
            st_d = StMulA;
          end
        end
      end
      StSqr: begin
        st_d = StIdle;
      end
      StMulA: begin
        if (step_q == MulALast) begin
          st_d   = StMulB;
          step_d = '0;
        end
      end
      StMulB: begin
        if (step_q == MulBLast) begin
          st_d   = StMulN;
          step_d = '0;
        end
      end
      StMulN: begin
        if (step_q == MulNLast) begin
          // a negative difference clamps the variance, skip its division
          st_d   = acc_q[AccW-1] ? StDivM : StDivV;
          step_d = '0;
        end
      end
      StDivV: begin
        if (step_q == DivVLast) begin
          st_d   = StDivM;
          step_d = '0;
        end
      end
      StDivM: begin
        if (step_q == DivMLast) begin
          st_d   = StSqrt;
          step_d = '0;
        end
      end
      StSqrt: begin
        if (step_q == SqrtLast) begin
          st_d   = StFin;
          step_d = '0;
        end
      end
      StFin: begin
        step_d = '0;
        if (!out_vld_q) begin
          st_d = StIdle;
        end
      end
      default: begin
        st_d   = StIdle;
        step_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      step_q    <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      sq_q      <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      if (in_fire && !s_axis_tdata[SampleW-1]) begin
        if (cnt_full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
          sum_q <= sum_q + SumW'(s_axis_tdata[SampleW-2:0]);
        end
      end
      if (st_q == StSqr) begin
        sq_q <= sq_q + SqW'(mul_p);
      end
      if (fin_go) begin
        cnt_q     <= '0;
        sum_q     <= '0;
        sq_q      <= '0;
        ovf_q     <= 1'b0;
        out_vld_q <= 1'b1;
      end else if (out_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        if (in_fire && s_axis_tdata[SampleW-1]) begin
          acc_q   <= '0;
          empty_q <= (cnt_q == '0);
          mean_q  <= '0;
          var_q   <= '0;
          std_q   <= '0;
        end
      end
      StMulA: begin
        if (step_q[0]) begin
          acc_q <= acc_q + part;
        end
      end
      StMulB: begin
        if (step_q[0]) begin
          acc_q <= acc_q - part;
        end
      end
      StMulN: begin
        if (step_q[0]) begin
          den_q <= {mul_p[31:0], 8'b0};
          if (acc_q[AccW-1]) begin
            rem_q  <= {23'b0, sum_q[SumW-1:MeanW]};
            quot_q <= {sum_q[MeanW-1:0], 23'b0};
          end else begin
            // quotient fits 46 bits, so the top of the dividend seeds the remainder
            rem_q  <= RemW'(acc_q[AccW-2:VarW]);
            quot_q <= acc_q[VarW-1:0];
          end
        end
      end
      StDivV: begin
        if (step_q == DivVLast) begin
          var_q  <= quot_nxt;
          rem_q  <= {23'b0, sum_q[SumW-1:MeanW]};
          quot_q <= {sum_q[MeanW-1:0], 23'b0};
        end else begin
          rem_q  <= step_rem;
          quot_q <= quot_nxt;
        end
      end
      StDivM: begin
        quot_q <= quot_nxt;
        if (step_q == DivMLast) begin
          mean_q <= quot_nxt[MeanW-1:0];
          acc_q  <= {27'b0, var_q, 8'b0};
          rem_q  <= '0;
          root_q <= '0;
        end else begin
          rem_q  <= step_rem;
        end
      end
      StSqrt: begin
        rem_q  <= step_rem;
        root_q <= {root_q[RootW-2:0], cs_ge};
        acc_q  <= acc_q << 2;
        if (step_q == SqrtLast) begin
          std_q <= {root_q[StdW-2:0], cs_ge};
        end
      end
      StFin: begin
        if (!out_vld_q) begin
          out_data_q <= {4'b0, std_q, var_q, mean_q};
          out_user_q <= {ovf_q, empty_q};
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountCap)
    else $error("sample count above its cap");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("empty set result carries nonzero data");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      ((64'(m_axis_tdata[91:69]) * 64'(m_axis_tdata[91:69])) <=
       {10'b0, m_axis_tdata[68:23], 8'b0}))
    else $error("std_dev squared exceeds scaled variance");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rmvs_mul.sv */
// shared 24 x 24 multiplier with registered product
`default_nettype none

module rmvs_mul (
  input  wire logic                        clk_i,
  input  wire logic [rmvs_pkg::MulW-1:0]   a_i,
  input  wire logic [rmvs_pkg::MulW-1:0]   b_i,
  output logic      [rmvs_pkg::ProdW-1:0]  p_o
);
  import rmvs_pkg::*;

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* hw/rtl/rmvs_csub.sv */
// shared compare and subtract step for the divider and the square root
`default_nettype none

module rmvs_csub (
  input  wire logic [rmvs_pkg::CsW-1:0] a_i,
  input  wire logic [rmvs_pkg::CsW-1:0] b_i,
  output logic                          ge_o,
  output logic      [rmvs_pkg::CsW-1:0] diff_o
);
  import rmvs_pkg::*;

  logic [CsW:0] sub;

  always_comb begin
    sub    = {1'b0, a_i} - {1'b0, b_i};
    ge_o   = ~sub[CsW];
    diff_o = sub[CsW-1:0];
  end

endmodule

`default_nettype wire

/* dv/tb_running_mean_variance_stddev_unit.sv */
// testbench for the running mean, variance and standard deviation unit
module tb_running_mean_variance_stddev_unit;
  import rmvs_pkg::*;

  localparam int unsigned VarLo = MeanW;
  localparam int unsigned StdLo = MeanW + VarW;
  localparam int unsigned PadLo = MeanW + VarW + StdW;
  localparam int unsigned RandItems = 1900;
  localparam int unsigned DrainCycles = 200;

  localparam logic [SampleW-1:0] SmpMax  = 24'h7FFFFF;
  localparam logic [SampleW-1:0] EndMin  = 24'h800000;  // most negative
  localparam logic [SampleW-1:0] EndAll1 = 24'hFFFFFF;  // -1 lsb
  localparam logic [SampleW-1:0] EndHalf = 24'hFFFF80;  // -0.5

  typedef struct packed {
    logic [MeanW-1:0] mean;
    logic [VarW-1:0]  variance;
    logic [StdW-1:0]  std_dev;
    logic             empty_set;
    logic             count_overflow;
  } stats_t;

  typedef struct packed {
    logic [SampleW-1:0] smp;
    logic [31:0]        reps;
    logic               typed;
    stats_t             want;
  } step_row_t;

  typedef enum logic [1:0] {MixWide, MixTiny, MixHigh, MixNear} mix_e;

  localparam stats_t EmptyRes = '{mean: '0, variance: '0, std_dev: '0,
                                  empty_set: 1'b1, count_overflow: 1'b0};

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  // predictor state
  logic [CntW-1:0] acc_count;
  logic [SumW-1:0] acc_sum;
  logic [SqW-1:0]  acc_sqsum;
  logic            acc_ovf;

  stats_t      pending_stats[$];
  int unsigned err_count = 0;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned sink_hold_req;

  running_mean_variance_stddev_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (err_count < 40) begin
      $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    end
    err_count++;
  endtask

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // folds one sample into the set, or closes the set on a negative sample
  task automatic fold_sample(input logic [SampleW-1:0] smp, output bit has_res,
                             output stats_t res);
    logic [22:0]     mag;
    logic [SumW-1:0] mean_full;
    logic [127:0]    n_q;
    logic [127:0]    s_s;
    logic [127:0]    den;
    logic [127:0]    quot;
    logic [31:0]     root;
    has_res = 1'b0;
    res = '0;
    mag = smp[22:0];
    if (!smp[SampleW-1]) begin
      if (acc_count >= CountCap) begin
        acc_ovf = 1'b1;
      end else begin
        acc_count = acc_count + 1'b1;
        acc_sum   = acc_sum + SumW'(mag);
        acc_sqsum = acc_sqsum + SqW'(mag) * SqW'(mag);
      end
    end else begin
      has_res = 1'b1;
      if (acc_count == '0) begin
        res.empty_set = 1'b1;
      end else begin
        mean_full = acc_sum / SumW'(acc_count);
        res.mean = mean_full[MeanW-1:0];
        n_q = 128'(acc_count) * 128'(acc_sqsum);
        s_s = 128'(acc_sum) * 128'(acc_sum);
        den = 128'(acc_count) * 128'(acc_count) * 128'd256;
        // clamp at zero if the square of the sum dominates
        if (n_q >= s_s) begin
          quot = (n_q - s_s) / den;
          res.variance = quot[VarW-1:0];
        end
        root = int_sqrt(64'(res.variance) << 8);
        res.std_dev = root[StdW-1:0];
      end
      res.count_overflow = acc_ovf;
      acc_count = '0;
      acc_sum   = '0;
      acc_sqsum = '0;
      acc_ovf   = 1'b0;
    end
  endtask

  // called and returns at a falling edge
  task automatic push_sample(input logic [SampleW-1:0] smp, input logic typed,
                             input stats_t want);
    bit     has_res;
    stats_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= SampleW'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fold_sample(smp, has_res, res);
    if (has_res) pending_stats.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    stats_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_stats.size() == 0) begin
        flag_mismatch("result with none pending", 64'(m_axis_tdata), '0);
      end else begin
        exp_res = pending_stats.pop_front();
        if (m_axis_tdata[MeanW-1:0] !== exp_res.mean)
          flag_mismatch("mean", 64'(m_axis_tdata[MeanW-1:0]), 64'(exp_res.mean));
        if (m_axis_tdata[VarLo +: VarW] !== exp_res.variance)
          flag_mismatch("variance", 64'(m_axis_tdata[VarLo +: VarW]), 64'(exp_res.variance));
        if (m_axis_tdata[StdLo +: StdW] !== exp_res.std_dev)
          flag_mismatch("std_dev", 64'(m_axis_tdata[StdLo +: StdW]), 64'(exp_res.std_dev));
        if (m_axis_tdata[OutDataW-1:PadLo] !== '0)
          flag_mismatch("tdata padding", 64'(m_axis_tdata[OutDataW-1:PadLo]), '0);
        if (m_axis_tuser[0] !== exp_res.empty_set)
          flag_mismatch("empty_set", 64'(m_axis_tuser[0]), 64'(exp_res.empty_set));
        if (m_axis_tuser[1] !== exp_res.count_overflow)
          flag_mismatch("count_overflow", 64'(m_axis_tuser[1]), 64'(exp_res.count_overflow));
      end
    end
  end

  // result side backpressure, with one long hold-off on request
  initial begin : drive_sink
    int unsigned hold_left;
    bit          hold_taken;
    hold_left     = 0;
    hold_taken    = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_taken && sink_hold_req != 0) begin
        hold_left  = sink_hold_req;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : stimulus
    step_row_t   dir_rows [16];
    int unsigned rnd_items;
    int unsigned set_len;
    int unsigned pick;
    bit          hold_fired;
    mix_e        mix;
    logic [22:0] base;
    logic [22:0] mag;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    acc_count     = '0;
    acc_sum       = '0;
    acc_sqsum     = '0;
    acc_ovf       = 1'b0;
    src_idle_pct  = 7;
    sink_idle_pct = 7;
    sink_hold_req = 0;
    hold_fired    = 1'b0;
    rnd_items     = 0;

    // sample, repeat, typed, {mean, variance, std_dev, empty_set, count_overflow}
    dir_rows = '{
      '{EndAll1,      32'd1,           1'b1, EmptyRes},
      '{EndMin,       32'd1,           1'b1, EmptyRes},
      '{24'd0,        32'd1,           1'b0, '0},
      '{EndHalf,      32'd1,           1'b1, '0},
      '{SmpMax,       32'd1,           1'b0, '0},
      '{EndMin,       32'd1,           1'b1, '{23'h7FFFFF, 46'd0, 23'd0, 1'b0, 1'b0}},
      '{24'd0,        32'd1,           1'b0, '0},
      '{SmpMax,       32'd1,           1'b0, '0},
      '{EndAll1,      32'd1,           1'b0, '0},
      '{24'h000100,   32'd1,           1'b0, '0},
      '{24'h000300,   32'd1,           1'b0, '0},
      '{EndAll1,      32'd1,           1'b1, '{23'h200, 46'h100, 23'h100, 1'b0, 1'b0}},
      '{24'h000001,   32'd3,           1'b0, '0},
      '{24'h400000,   32'd1,           1'b0, '0},
      '{24'hC00001,   32'd1,           1'b0, '0},
      '{EndAll1,      32'd1,           1'b1, EmptyRes}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) push_sample(dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].want);
    end

    while (rnd_items < RandItems) begin
      // a calm stretch with no idling on either side
      src_idle_pct  = (rnd_items >= 600 && rnd_items < 1000) ? 0 : 7;
      sink_idle_pct = src_idle_pct;
      if (!hold_fired && rnd_items >= 1300) begin
        sink_hold_req = 500;
        hold_fired = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 8)       set_len = 0;
      else if (pick < 65) set_len = $urandom_range(8, 1);
      else if (pick < 95) set_len = $urandom_range(40, 9);
      else                set_len = $urandom_range(160, 41);
      mix  = mix_e'($urandom_range(3));
      base = 23'($urandom);
      repeat (set_len) begin
        case (mix)
          MixWide: mag = 23'($urandom);
          MixTiny: mag = 23'($urandom_range(255));
          MixHigh: mag = 23'h7FFFFF - 23'($urandom_range(255));
          default: mag = {base[22:8], 8'($urandom)};
        endcase
        push_sample({1'b0, mag}, 1'b0, '0);
      end
      push_sample({1'b1, 23'($urandom)}, 1'b0, '0);
      rnd_items += set_len + 1;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
